@@ rtl/core/text_encoding_sniffer_macros.svh @@
// assertion macros for the bound checker tes_checker
`ifndef TEXT_ENCODING_SNIFFER_MACROS_SVH
`define TEXT_ENCODING_SNIFFER_MACROS_SVH

// checked only while out of reset
`define TES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TES_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tes_pkg.sv @@
`timescale 1ns / 1ps

package tes_pkg;

	localparam int TES_SCAN_WINDOW = 4096;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;
	localparam int ENC_W      = 3;

	localparam logic [ENC_W-1:0] ENC_ANSI     = 3'd0;
	localparam logic [ENC_W-1:0] ENC_UTF8     = 3'd1;
	localparam logic [ENC_W-1:0] ENC_UTF8_BOM = 3'd2;
	localparam logic [ENC_W-1:0] ENC_UTF16_LE = 3'd3;
	localparam logic [ENC_W-1:0] ENC_UTF16_BE = 3'd4;

	// byte order marks
	localparam logic [7:0] BOM8_B0  = 8'hEF;
	localparam logic [7:0] BOM8_B1  = 8'hBB;
	localparam logic [7:0] BOM8_B2  = 8'hBF;
	localparam logic [7:0] BOM16_FF = 8'hFF;
	localparam logic [7:0] BOM16_FE = 8'hFE;

	// utf-8 lead ranges and continuation form
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	typedef struct packed {
		logic [IN_DATA_W-1:0] data_byte;
		logic                 has_byte;
		logic                 last_byte;
	} item_t;

	typedef struct packed {
		logic [ENC_W-1:0] encoding;
		logic             utf8_ok;
	} result_t;

endpackage

@@ rtl/core/tes_in_stage.sv @@
`timescale 1ns / 1ps

module tes_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [tes_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic                          s_axis_tuser,
	input  logic                          s_axis_tlast,
	input  logic                          advance,
	output logic                          valid_s1,
	output tes_pkg::item_t                item_s1
);
	import tes_pkg::*;

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.data_byte <= s_axis_tdata;
			item_s1.has_byte  <= s_axis_tuser;
			item_s1.last_byte <= s_axis_tlast;
		end
	end

endmodule

@@ rtl/core/tes_scan.sv @@
`timescale 1ns / 1ps

module tes_scan #(
	parameter int SCAN_WINDOW = tes_pkg::TES_SCAN_WINDOW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  tes_pkg::item_t   item,
	output tes_pkg::result_t res
);
	import tes_pkg::*;

	localparam int CW = $clog2(SCAN_WINDOW + 1);
	localparam int ZW = $clog2((SCAN_WINDOW + 1) / 2 + 1);
	localparam logic [CW-1:0] WIN = CW'(SCAN_WINDOW);

	logic [23:0]   head_q, head_n;
	logic [CW-1:0] count_q, count_n;
	logic [ZW-1:0] zeven_q, zeven_n;
	logic [ZW-1:0] zodd_q, zodd_n;
	logic [1:0]    cont_q, cont_n;
	logic          bad_q, bad_n;

	logic [7:0]    b;
	logic          ok;
	logic [CW+1:0] zeros4;
	logic [ZW+1:0] zeven4;
	logic [ZW+1:0] zodd4;
	logic          dense;
	logic [ENC_W-1:0] enc;

	assign b = item.data_byte;

	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		zeven_n = zeven_q;
		zodd_n  = zodd_q;
		cont_n  = cont_q;
		bad_n   = bad_q;
		if (item.has_byte) begin
			if (count_q < CW'(3)) begin
				head_n[8*count_q[1:0] +: 8] = b;
			end
			if (count_q < WIN) begin
				if (b == 8'h00) begin
					if (count_q[0]) begin
						zodd_n = zodd_q + ZW'(1);
					end else begin
						zeven_n = zeven_q + ZW'(1);
					end
				end
				count_n = count_q + CW'(1);
			end
			if (!bad_q) begin
				if (cont_q != 2'd0) begin
					if ((b & CONT_MASK) != CONT_TAG) begin
						bad_n = 1'b1;
					end else begin
						cont_n = cont_q - 2'd1;
					end
				end else if (!b[7]) begin
					cont_n = 2'd0;
				end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
					cont_n = 2'd1;
				end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
					cont_n = 2'd2;
				end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
					cont_n = 2'd3;
				end else begin
					bad_n = 1'b1;
				end
			end
		end
	end

	// verdict on the state as it stands after this byte
	assign ok     = !bad_n && (cont_n == 2'd0);
	assign zeros4 = ((CW+2)'(zeven_n) + (CW+2)'(zodd_n)) << 2;
	assign zeven4 = (ZW+2)'(zeven_n) << 2;
	assign zodd4  = (ZW+2)'(zodd_n) << 2;
	assign dense  = zeros4 >= (CW+2)'(count_n);

	always_comb begin
		if (count_n >= CW'(3) && head_n[7:0] == BOM8_B0 && head_n[15:8] == BOM8_B1
				&& head_n[23:16] == BOM8_B2) begin
			enc = ENC_UTF8_BOM;
		end else if (count_n >= CW'(2) && head_n[7:0] == BOM16_FF
				&& head_n[15:8] == BOM16_FE) begin
			enc = ENC_UTF16_LE;
		end else if (count_n >= CW'(2) && head_n[7:0] == BOM16_FE
				&& head_n[15:8] == BOM16_FF) begin
			enc = ENC_UTF16_BE;
		end else if (count_n == '0) begin
			enc = ENC_ANSI;
		end else if (dense && (ZW+2)'(zodd_n) > zeven4) begin
			enc = ENC_UTF16_LE;
		end else if (dense && (ZW+2)'(zeven_n) > zodd4) begin
			enc = ENC_UTF16_BE;
		end else if (ok) begin
			enc = ENC_UTF8;
		end else begin
			enc = ENC_ANSI;
		end
	end

	assign res.encoding = enc;
	assign res.utf8_ok  = ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			zeven_q <= '0;
			zodd_q  <= '0;
			cont_q  <= '0;
			bad_q   <= 1'b0;
		end else if (fire) begin
			if (item.last_byte) begin
				head_q  <= '0;
				count_q <= '0;
				zeven_q <= '0;
				zodd_q  <= '0;
				cont_q  <= '0;
				bad_q   <= 1'b0;
			end else begin
				head_q  <= head_n;
				count_q <= count_n;
				zeven_q <= zeven_n;
				zodd_q  <= zodd_n;
				cont_q  <= cont_n;
				bad_q   <= bad_n;
			end
		end
	end

endmodule

@@ rtl/core/tes_out_stage.sv @@
`timescale 1ns / 1ps

module tes_out_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  tes_pkg::result_t               res,
	output logic                           can_take,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tes_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tes_pkg::*;

	result_t res_q;

	assign can_take = !m_axis_tvalid || m_axis_tready;
	assign m_axis_tdata = {(OUT_DATA_W - ENC_W - 1)'(0), res_q.utf8_ok, res_q.encoding};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ rtl/core/text_encoding_sniffer.sv @@
// a last beat passes through the input register and then the verdict register to m_axis
// throughput: one beat per cycle while no final beat is held up, set by the single scan stage
// a final beat waits in the input register only while the verdict register is full and not taken
// reset: arst_n low clears both valid flags and all scan state at once
`timescale 1ns / 1ps

module text_encoding_sniffer #(
	parameter int SCAN_WINDOW = tes_pkg::TES_SCAN_WINDOW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// byte stream in
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tes_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic                           s_axis_tuser,  // [0] has_byte
	input  logic                           s_axis_tlast,  // last_byte
	// verdict out, one beat per file
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tes_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [2:0] encoding, [3] utf8_ok
);
	import tes_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    can_take;
	logic    advance;
	logic    fire;
	result_t res;

	// a non-final beat only updates scan state and never blocks;
	// a final beat needs room in the verdict register
	assign advance = valid_s1 && (!item_s1.last_byte || can_take);
	assign fire    = advance;

	// input register: takes a new beat when empty or whenever the held one moves on
	tes_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	// head bytes, zero parity counts and utf-8 tracker; verdict is formed
	// from the updated state and all scan state clears after a final beat
	tes_scan #(
		.SCAN_WINDOW (SCAN_WINDOW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	// verdict register, holds until the downstream side takes it
	tes_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire && item_s1.last_byte),
		.res           (res),
		.can_take      (can_take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

@@ rtl/core/tes_checker.sv @@
`timescale 1ns / 1ps
`include "text_encoding_sniffer_macros.svh"

module tes_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [tes_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                           s_axis_tuser,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [tes_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tes_pkg::*;

	`TES_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "verdict beat changed while stalled")
	`TES_ASSERT(a_enc_range, m_axis_tvalid |-> m_axis_tdata[2:0] <= ENC_UTF16_BE, "encoding code out of range")
	`TES_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0, "verdict padding bits not zero")
	`TES_ASSERT(a_utf8_ok, m_axis_tvalid && m_axis_tdata[2:0] == ENC_UTF8 |-> m_axis_tdata[3], "utf-8 verdict without passing check")
	`TES_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_axis_tvalid, "verdict valid during reset")

endmodule

bind text_encoding_sniffer tes_checker u_tes_checker (.*);

@@ tb/sv/text_encoding_sniffer_checker.sv @@
`timescale 1ns / 1ps

module text_encoding_sniffer_checker #(
	parameter int SCAN_WINDOW = tes_pkg::TES_SCAN_WINDOW
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tuser,  // [0] has_byte
	input  logic       s_axis_tlast,  // last_byte
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,  // [2:0] encoding, [3] utf8_ok
	output int         mismatches,
	output int         verdicts_pending,
	output int         verdicts_checked
);
	import tes_pkg::*;

	localparam int PRINT_CAP = 40;

	result_t     verdict_q[$];
	logic [23:0] head;
	int          scanned;
	int          zeros_even;
	int          zeros_odd;
	int          cont_left;
	logic        utf8_broken;

	function automatic void clear_file();
		head        = '0;
		scanned     = 0;
		zeros_even  = 0;
		zeros_odd   = 0;
		cont_left   = 0;
		utf8_broken = 1'b0;
	endfunction

	function automatic void absorb(input logic [7:0] b);
		if (scanned < 3)
			head[8*scanned +: 8] = b;
		// zero census only inside the scan window
		if (scanned < SCAN_WINDOW) begin
			if (b == 8'h00) begin
				if (scanned % 2 == 1)
					zeros_odd++;
				else
					zeros_even++;
			end
			scanned++;
		end
		if (!utf8_broken) begin
			if (cont_left != 0) begin
				if ((b & CONT_MASK) != CONT_TAG)
					utf8_broken = 1'b1;
				else
					cont_left--;
			end else if (b[7]) begin
				if (b >= LEAD2_LO && b <= LEAD2_HI)
					cont_left = 1;
				else if (b >= LEAD3_LO && b <= LEAD3_HI)
					cont_left = 2;
				else if (b >= LEAD4_LO && b <= LEAD4_HI)
					cont_left = 3;
				else
					utf8_broken = 1'b1;
			end
		end
	endfunction

	function automatic result_t judge();
		result_t    r;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       wide;
		b0 = head[7:0];
		b1 = head[15:8];
		b2 = head[23:16];
		// a cut-short sequence fails the check too
		r.utf8_ok = !utf8_broken && cont_left == 0;
		wide = (zeros_even + zeros_odd) * 4 >= scanned;
		if (scanned >= 3 && b0 == BOM8_B0 && b1 == BOM8_B1 && b2 == BOM8_B2)
			r.encoding = ENC_UTF8_BOM;
		else if (scanned >= 2 && b0 == BOM16_FF && b1 == BOM16_FE)
			r.encoding = ENC_UTF16_LE;
		else if (scanned >= 2 && b0 == BOM16_FE && b1 == BOM16_FF)
			r.encoding = ENC_UTF16_BE;
		else if (scanned == 0)
			r.encoding = ENC_ANSI;
		else if (wide && zeros_odd > zeros_even * 4)
			r.encoding = ENC_UTF16_LE;
		else if (wide && zeros_even > zeros_odd * 4)
			r.encoding = ENC_UTF16_BE;
		else
			r.encoding = r.utf8_ok ? ENC_UTF8 : ENC_ANSI;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: verdict mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			verdict_q.delete();
			clear_file();
			mismatches       = 0;
			verdicts_checked = 0;
			verdicts_pending <= 0;
		end else begin
			// output first: a verdict never leaves on the edge its file ends
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("beat with no file pending", m_axis_tdata, 8'h00);
				end else begin
					want = verdict_q.pop_front();
					verdicts_checked++;
					if (m_axis_tdata[ENC_W-1:0] !== want.encoding)
						report_mismatch("encoding", 8'(m_axis_tdata[ENC_W-1:0]),
							8'(want.encoding));
					if (m_axis_tdata[3] !== want.utf8_ok)
						report_mismatch("utf8_ok", 8'(m_axis_tdata[3]), 8'(want.utf8_ok));
					if (m_axis_tdata[7:4] !== 4'h0)
						report_mismatch("tdata padding", 8'(m_axis_tdata[7:4]), 8'h00);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					absorb(s_axis_tdata);
				if (s_axis_tlast) begin
					verdict_q.push_back(judge());
					clear_file();
				end
			end
			verdicts_pending <= verdict_q.size();
		end
	end

endmodule

@@ tb/sv/text_encoding_sniffer_tb.sv @@
`timescale 1ns / 1ps

module text_encoding_sniffer_tb;
	import tes_pkg::*;

	// no new random file starts once this many byte and end-marker beats have gone in
	localparam int RANDOM_BEATS = 1900;
	// generous bound, far beyond the slowest legal run
	localparam int CYCLE_LIMIT  = 400000;
	// receiver hold-off, long enough to back the block up into its input
	localparam int STALL_CYCLES = 400;
	// percent of cycles each side sits idle while gaps are enabled
	localparam int GAP_PCT      = 26;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] data_byte
	logic       s_axis_tuser;   // [0] has_byte
	logic       s_axis_tlast;   // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [2:0] encoding, [3] utf8_ok

	int mismatches;
	int verdicts_pending;
	int verdicts_checked;

	// shared knobs: gaps on both sides, and a one-shot request for the long hold
	logic gaps_on       = 1'b1;
	logic stall_request = 1'b0;

	int cycle_count;
	int files_sent;
	int bytes_sent;
	int beats_sent;
	int markers_sent;
	int skip_beats;

	// bytes of the file being assembled
	logic [7:0] file_bytes[$];

	text_encoding_sniffer DUT (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.s_axis_tlast,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata
	);

	text_encoding_sniffer_checker verdict_check (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.s_axis_tlast,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.mismatches,
		.verdicts_pending,
		.verdicts_checked
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// watchdog: a hang ends the run as a failure
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d verdicts still pending", cycle_count,
			verdicts_pending);
		$display("text_encoding_sniffer verification failed");
		$finish;
	end

	// verdict side: random back-pressure, plus one long hold counted here
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
			end
		end
	end

	// offer one beat and hold it until the block takes it
	task automatic send_beat(input logic [7:0] d, input logic has, input logic last);
		while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= has;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (has || last)
			beats_sent++;
		else
			skip_beats++;
	endtask

	// stream the assembled file; the end is either on the final byte or a separate
	// end marker beat, and an empty file is always a lone marker
	task automatic send_file(input bit end_marker);
		int n;
		n = file_bytes.size();
		for (int i = 0; i < n; i++) begin
			// now and then a beat with neither flag, which the block must ignore
			if ($urandom_range(0, 99) < 4)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(file_bytes[i], 1'b1, !end_marker && i == n - 1);
		end
		if (end_marker || n == 0) begin
			send_beat(8'($urandom), 1'b0, 1'b1);
			markers_sent++;
		end
		bytes_sent += n;
		files_sent++;
		file_bytes.delete();
	endtask

	// idle the sender until every verdict owed has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0)
			@(posedge clk);
	endtask

	// well-formed utf-8 characters with random code points, ascii weighted
	function automatic void add_text(input int chars);
		logic [7:0] lead;
		int         conts;
		repeat (chars) begin
			case ($urandom_range(0, 9))
				5, 6: begin
					lead  = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
					conts = 1;
				end
				7, 8: begin
					lead  = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
					conts = 2;
				end
				9: begin
					lead  = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
					conts = 3;
				end
				default: begin
					lead  = 8'($urandom_range(0, 127));
					conts = 0;
				end
			endcase
			file_bytes.push_back(lead);
			repeat (conts)
				file_bytes.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
		end
	endfunction

	// utf-16 text, mostly ascii so the high byte is zero; some high bytes are
	// random to move the zero ratio around the thresholds
	function automatic void add_wide_text(input int chars, input bit little);
		logic [7:0] lo;
		logic [7:0] hi;
		repeat (chars) begin
			lo = 8'($urandom_range(1, 127));
			hi = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
			if (little) begin
				file_bytes.push_back(lo);
				file_bytes.push_back(hi);
			end else begin
				file_bytes.push_back(hi);
				file_bytes.push_back(lo);
			end
		end
	endfunction

	function automatic void add_noise(input int n, input int zero_pct);
		repeat (n)
			file_bytes.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom));
	endfunction

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed files
		// empty file: a lone end marker
		send_file(1'b1);
		// a single zero byte is all zeros at an even offset
		file_bytes = '{8'h00};
		send_file(1'b0);
		// a byte that can never start a character
		file_bytes = '{8'hFF};
		send_file(1'b0);
		// utf-8 mark with nothing after it
		file_bytes = '{BOM8_B0, BOM8_B1, BOM8_B2};
		send_file(1'b0);
		// utf-16 le mark, ended by a marker beat
		file_bytes = '{BOM16_FF, BOM16_FE};
		send_file(1'b1);
		// utf-16 be mark
		file_bytes = '{BOM16_FE, BOM16_FF};
		send_file(1'b0);
		// two-byte lead cut short by the end of file
		file_bytes = '{LEAD2_LO};
		send_file(1'b0);
		// highest four-byte lead with continuations at both ends of their range
		file_bytes = '{LEAD4_HI, 8'h80, 8'hBF, 8'h80};
		send_file(1'b0);
		// ignored beat, then a plain ascii file
		send_beat(8'hA5, 1'b0, 1'b0);
		file_bytes = '{8'h41};
		send_file(1'b0);
		// utf-16 le without a mark
		file_bytes = '{8'h41, 8'h00, 8'h42, 8'h00};
		send_file(1'b0);
		// overlong lead that the lax check still rejects
		file_bytes = '{8'hC0, 8'h80};
		send_file(1'b0);

		// random files
		while (beats_sent < RANDOM_BEATS) begin
			// a long stretch with neither side idling
			if (files_sent == 20)
				gaps_on = 1'b0;
			if (files_sent == 45)
				gaps_on = 1'b1;
			// pause until drained, then hold the receiver off while tiny files pile up
			if (files_sent == 70) begin
				wait_drained();
				stall_request = 1'b1;
				repeat (30) begin
					add_noise($urandom_range(1, 2), 30);
					send_file(1'b0);
				end
			end
			case ($urandom_range(0, 11))
				0: begin
					file_bytes = '{BOM8_B0, BOM8_B1, BOM8_B2};
					add_text($urandom_range(0, 20));
				end
				1: begin
					file_bytes = '{BOM16_FF, BOM16_FE};
					add_wide_text($urandom_range(0, 15), 1'b1);
				end
				2: begin
					file_bytes = '{BOM16_FE, BOM16_FF};
					add_wide_text($urandom_range(0, 15), 1'b0);
				end
				3: add_wide_text($urandom_range(1, 20), 1'b1);
				4: add_wide_text($urandom_range(1, 20), 1'b0);
				5, 6: add_text($urandom_range(0, 30));
				7: begin
					// valid text altered in one of three ways that can break it
					add_text($urandom_range(1, 20));
					case ($urandom_range(0, 2))
						0: file_bytes.insert($urandom_range(0, file_bytes.size()),
							8'($urandom));
						1: file_bytes.push_back(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
						default: file_bytes.push_back(($urandom_range(0, 1) == 0) ?
							8'($urandom_range(8'hC0, 8'hC1)) :
							8'($urandom_range(8'hF5, 8'hFF)));
					endcase
				end
				8: add_noise($urandom_range(1, 30), 0);
				9: add_noise($urandom_range(1, 30), $urandom_range(10, 60));
				10: begin
					// near misses of the marks
					case ($urandom_range(0, 5))
						0: file_bytes = '{BOM8_B0};
						1: file_bytes = '{BOM8_B0, BOM8_B1};
						2: file_bytes = '{BOM16_FF};
						3: file_bytes = '{BOM16_FE};
						4: file_bytes = '{BOM16_FF, BOM16_FF};
						default: file_bytes = '{BOM8_B0, BOM8_B1, 8'hBE};
					endcase
					add_text($urandom_range(0, 10));
				end
				default: ;  // empty file
			endcase
			send_file($urandom_range(0, 3) == 0);
		end

		// let the last verdict through and leave room for a stray one
		wait_drained();
		repeat (8) @(posedge clk);

		$display("run covered %0d files: %0d bytes, %0d end markers, %0d ignored beats",
			files_sent, bytes_sent, markers_sent, skip_beats);
		$display("%0d verdicts compared, with marks, wide text, broken utf-8 and a long stall",
			verdicts_checked);
		if (mismatches == 0 && verdicts_pending == 0)
			$display("text_encoding_sniffer verification clean");
		else
			$display("text_encoding_sniffer verification failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tes_pkg.sv
rtl/core/tes_in_stage.sv
rtl/core/tes_scan.sv
rtl/core/tes_out_stage.sv
rtl/core/text_encoding_sniffer.sv
rtl/core/tes_checker.sv
tb/sv/text_encoding_sniffer_checker.sv
tb/sv/text_encoding_sniffer_tb.sv
